// ===== rtl/core/fpur_pkg.sv =====
// Shared constants, types and character functions of the file path to URL rewriter.
`default_nettype none

package fpur_pkg;

    // Depth of the held prefix and the widths that follow from it.
    localparam int PREFIX_DEPTH = 16;
    localparam int ADDR_W       = $clog2(PREFIX_DEPTH);
    localparam int IDX_W        = $clog2(PREFIX_DEPTH + 2);

    // Request codes on the input channel.
    localparam logic [1:0] REQ_TEXT  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;

    // Text modes.
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_HOLD  = 2'd1;
    localparam logic [1:0] MODE_PASS  = 2'd2;
    localparam logic [1:0] MODE_PATH  = 2'd3;

    // Phases of the URL scheme scan.
    localparam logic [2:0] PH_NONE   = 3'd0;
    localparam logic [2:0] PH_SCHEME = 3'd1;
    localparam logic [2:0] PH_COLON  = 3'd2;
    localparam logic [2:0] PH_SLASH1 = 3'd3;
    localparam logic [2:0] PH_SLASH2 = 3'd4;
    localparam logic [2:0] PH_URL    = 3'd5;

    localparam logic [31:0] FILE_TAG     = 32'h4649_4C45;
    localparam logic [7:0]  FILE_TAG_LEN = 8'd4;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_PCT    = 8'h25;

    // Last header index: "file://" and "file:///".
    localparam logic [2:0] HDR_LAST_DOUBLE = 3'd6;
    localparam logic [2:0] HDR_LAST_TRIPLE = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       done;
    } enc_word_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_escaped(input logic [7:0] b);
        return b == CH_COLON || b == CH_QUEST || b == CH_HASH ||
               b == CH_LBRACK || b == CH_RBRACK || b == CH_AT;
    endfunction

    // The two hex digits that follow the percent sign.
    function automatic logic [15:0] esc_digits(input logic [7:0] b);
        logic [15:0] d;
        case (b)
            CH_COLON:  d = {8'h33, 8'h61};
            CH_QUEST:  d = {8'h33, 8'h46};
            CH_HASH:   d = {8'h32, 8'h33};
            CH_LBRACK: d = {8'h35, 8'h42};
            CH_RBRACK: d = {8'h35, 8'h44};
            CH_AT:     d = {8'h34, 8'h30};
            default:   d = 16'h0000;
        endcase
        return d;
    endfunction

    // Characters of "file:///"; the short header stops one earlier.
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h65;
            3'd4:    c = CH_COLON;
            default: c = CH_SLASH;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] scan_step(input logic [2:0] ph, input logic [7:0] b);
        logic [2:0] np;
        case (ph)
            PH_SCHEME:
            begin
                if (b == CH_COLON)
                    np = PH_COLON;
                else if (b == CH_SLASH || b == CH_BSLASH)
                    np = PH_NONE;
                else
                    np = PH_SCHEME;
            end
            PH_COLON, PH_SLASH1:
                np = (b == CH_SLASH) ? ph + 3'd1 : PH_NONE;
            PH_SLASH2:
                np = (b == CH_SLASH) ? PH_SLASH2 : PH_URL;
            default:
                np = PH_NONE;
        endcase
        return np;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpur_if.sv =====
// Valid/ready channel interfaces for the input stream and the result stream.
`default_nettype none

interface fpur_stream_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        text_last;
    logic [31:0] tag_head;
    logic [7:0]  tag_length;

    modport source (output valid, req_type, data_byte, text_last, tag_head, tag_length,
                    input ready);
    modport sink   (input valid, req_type, data_byte, text_last, tag_head, tag_length,
                    output ready);
endinterface

interface fpur_result_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_end_of_text;
    logic       out_last;
    logic       prefix_overflow;

    modport source (output valid, out_kind, out_byte, out_end_of_text, out_last,
                    prefix_overflow, input ready);
    modport sink   (input valid, out_kind, out_byte, out_end_of_text, out_last,
                    prefix_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fpur_byte_encoder.sv =====
// Turns one text byte into its output words: copied, slash-mapped or percent-escaped.
`default_nettype none

module fpur_byte_encoder (
    input  wire logic [7:0]      in_byte,
    input  wire logic            raw,
    input  wire logic [1:0]      sub,
    output fpur_pkg::enc_word_t  word
);
    import fpur_pkg::*;

    logic [15:0] digits;

    assign digits = esc_digits(in_byte);

    always_comb
    begin
        word.ch   = in_byte;
        word.done = 1'b1;
        if (!raw)
        begin
            if (in_byte == CH_BSLASH)
            begin
                word.ch = CH_SLASH;
            end
            else if (is_escaped(in_byte))
            begin
                case (sub)
                    2'd0:    word.ch = CH_PCT;
                    2'd1:    word.ch = digits[15:8];
                    default: word.ch = digits[7:0];
                endcase
                word.done = (sub == 2'd2);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/file_path_to_url_rewriter_top.sv =====
// Top level of the file path to file URL rewriter.
//
// The stream channel takes one word per text byte or structure event; the result
// channel gives text bytes and passed-on events, out_last marking the final word
// caused by one input word. Both are valid/ready; a word moves when both are high.
// An accepted event goes to the event state, which puts its result word into the
// output register once it is free. While a text in a FILE tag is undecided, its
// bytes are written to the prefix memory and give nothing until the text is known
// to be a URL or a path. Release then walks the memory: a header of 7 or 8
// characters where the path needs one, then per byte a memory read and one to
// three output words (three for a percent escape). Any other byte passes from its
// accept through the fetch state and one to three output words to the next accept.
// Input is taken only while idle, not during an event, a byte or a walk; one output
// register parts the two sides, so a stalled receiver holds the walk but not the
// next accept once the walk has finished. Reset clears the tag flag, the text mode
// and the walk; the memory keeps its contents, only read once written in the same text.
`default_nettype none

module file_path_to_url_rewriter_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fpur_stream_if.sink   stream,
    fpur_result_if.source result
);
    import fpur_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HDR   = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_EVT   = 3'd4;

    logic [7:0] mem [PREFIX_DEPTH];

    logic [2:0]       state_reg, state_next;
    logic             flag_reg, flag_next;
    logic [1:0]       mode_reg, mode_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       first_reg [3];

    logic [7:0]       b_hold_reg, b_hold_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] raw_end_reg, raw_end_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [2:0]       hdr_idx_reg, hdr_idx_next;
    logic [2:0]       hdr_last_reg, hdr_last_next;
    logic             ovf_hold_reg, ovf_hold_next;
    logic             last_hold_reg, last_hold_next;
    logic [1:0]       sub_reg, sub_next;
    logic [7:0]       rdata_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_eot_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;

    // Decode of an incoming text byte against the current text state.
    logic             in_fire;
    logic [1:0]       eff_mode;
    logic [2:0]       phase0;
    logic [IDX_W-1:0] cnt;
    logic [IDX_W-1:0] n_new;
    logic [2:0]       np;
    logic [7:0]       buf0, buf1, buf2;
    logic             rel_hdr;
    logic [2:0]       rel_hdr_last;
    logic [IDX_W-1:0] rel_start;
    logic [IDX_W-1:0] rel_raw;
    logic             mem_we;

    // Walk and output side.
    logic             j_is_last;
    logic [7:0]       cur_byte;
    enc_word_t        enc;
    logic             emit_valid;
    logic             emit_go;
    logic             emit_final;
    logic             emit_kind;
    logic [7:0]       emit_byte;
    logic             slot_free;

    assign stream.ready = (state_reg == ST_IDLE);
    assign in_fire      = stream.valid && stream.ready;

    assign eff_mode = (mode_reg != MODE_START) ? mode_reg :
                      (flag_reg ? MODE_HOLD : MODE_PASS);
    assign phase0   = (mode_reg != MODE_START) ? phase_reg :
                      (is_letter(stream.data_byte) ? PH_SCHEME : PH_NONE);
    assign cnt      = (mode_reg != MODE_START) ? count_reg : '0;
    assign n_new    = cnt + IDX_W'(1);
    assign np       = scan_step(phase0, stream.data_byte);

    // The held bytes start at the front of the text; the newest byte stays outside memory.
    assign buf0 = (cnt > IDX_W'(0)) ? first_reg[0] : stream.data_byte;
    assign buf1 = (cnt > IDX_W'(1)) ? first_reg[1] : stream.data_byte;
    assign buf2 = (cnt > IDX_W'(2)) ? first_reg[2] : stream.data_byte;

    always_comb
    begin
        rel_hdr      = 1'b0;
        rel_hdr_last = HDR_LAST_DOUBLE;
        rel_start    = '0;
        rel_raw      = '0;
        if (buf0 == CH_SLASH)
        begin
            rel_hdr = 1'b1;
        end
        else if (buf0 == CH_BSLASH)
        begin
            rel_hdr = 1'b1;
            // A UNC prefix drops its two backslashes unless a third one follows.
            if (n_new > IDX_W'(1) && buf1 == CH_BSLASH &&
                !(n_new > IDX_W'(2) && buf2 == CH_BSLASH))
                rel_start = IDX_W'(2);
        end
        else if (is_letter(buf0) && n_new > IDX_W'(2) && buf1 == CH_COLON &&
                 buf2 == CH_BSLASH)
        begin
            rel_hdr      = 1'b1;
            rel_hdr_last = HDR_LAST_TRIPLE;
            rel_raw      = IDX_W'(2);
        end
    end

    assign j_is_last = (j_reg == n_reg - IDX_W'(1));
    assign cur_byte  = j_is_last ? b_hold_reg : rdata_reg;

    fpur_byte_encoder u_encoder (
        .in_byte (cur_byte),
        .raw     (j_reg < raw_end_reg),
        .sub     (sub_reg),
        .word    (enc)
    );

    assign slot_free  = !out_valid_reg || result.ready;
    assign emit_valid = (state_reg == ST_HDR) || (state_reg == ST_EMIT) ||
                        (state_reg == ST_EVT);
    assign emit_go    = emit_valid && slot_free;

    always_comb
    begin
        emit_kind  = 1'b0;
        emit_byte  = enc.ch;
        emit_final = enc.done && j_is_last;
        case (state_reg)
            ST_HDR:
            begin
                emit_byte  = header_char(hdr_idx_reg);
                emit_final = (hdr_idx_reg == hdr_last_reg) && (start_reg == n_reg);
            end
            ST_EVT:
            begin
                emit_kind  = 1'b1;
                emit_byte  = 8'h00;
                emit_final = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        flag_next      = flag_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        b_hold_next    = b_hold_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        raw_end_next   = raw_end_reg;
        start_next     = start_reg;
        hdr_idx_next   = hdr_idx_reg;
        hdr_last_next  = hdr_last_reg;
        ovf_hold_next  = ovf_hold_reg;
        last_hold_next = last_hold_reg;
        sub_next       = sub_reg;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (stream.req_type != REQ_TEXT)
                    begin
                        if (stream.req_type == REQ_START)
                            flag_next = (stream.tag_length == FILE_TAG_LEN) &&
                                        (stream.tag_head == FILE_TAG);
                        state_next = ST_EVT;
                    end
                    else
                    begin
                        b_hold_next    = stream.data_byte;
                        last_hold_next = stream.text_last;
                        hdr_idx_next   = 3'd0;
                        sub_next       = 2'd0;
                        mode_next      = eff_mode;
                        case (eff_mode)
                            MODE_HOLD:
                            begin
                                n_next = n_new;
                                if (np == PH_URL)
                                begin
                                    j_next        = '0;
                                    raw_end_next  = n_new;
                                    start_next    = '0;
                                    ovf_hold_next = 1'b0;
                                    mode_next     = MODE_PASS;
                                    state_next    = ST_FETCH;
                                end
                                else if ((np == PH_NONE && n_new >= IDX_W'(3)) ||
                                         stream.text_last || cnt >= IDX_W'(PREFIX_DEPTH))
                                begin
                                    ovf_hold_next = !((np == PH_NONE && n_new >= IDX_W'(3)) ||
                                                      stream.text_last);
                                    phase_next    = ovf_hold_next ? PH_SCHEME : PH_NONE;
                                    j_next        = rel_start;
                                    raw_end_next  = rel_raw;
                                    start_next    = rel_start;
                                    hdr_last_next = rel_hdr_last;
                                    mode_next     = MODE_PATH;
                                    state_next    = rel_hdr ? ST_HDR : ST_FETCH;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    count_next = n_new;
                                    phase_next = np;
                                end
                            end
                            MODE_PASS:
                            begin
                                n_next        = IDX_W'(1);
                                j_next        = '0;
                                raw_end_next  = IDX_W'(1);
                                ovf_hold_next = 1'b0;
                                state_next    = ST_FETCH;
                            end
                            default:
                            begin
                                n_next        = IDX_W'(1);
                                j_next        = '0;
                                raw_end_next  = '0;
                                ovf_hold_next = phase_reg[0];
                                state_next    = ST_FETCH;
                            end
                        endcase
                        if (stream.text_last)
                        begin
                            mode_next  = MODE_START;
                            count_next = '0;
                            phase_next = PH_NONE;
                        end
                    end
                end
            end
            ST_HDR:
            begin
                if (emit_go)
                begin
                    if (hdr_idx_reg == hdr_last_reg)
                        state_next = (start_reg == n_reg) ? ST_IDLE : ST_FETCH;
                    else
                        hdr_idx_next = hdr_idx_reg + 3'd1;
                end
            end
            ST_FETCH:
            begin
                sub_next   = 2'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    if (enc.done)
                    begin
                        sub_next = 2'd0;
                        if (j_is_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            j_next     = j_reg + IDX_W'(1);
                            state_next = ST_FETCH;
                        end
                    end
                    else
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            ST_EVT:
            begin
                if (emit_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flag_reg      <= 1'b0;
            mode_reg      <= MODE_START;
            count_reg     <= '0;
            phase_reg     <= PH_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and walk registers need no reset.
    always_ff @(posedge clk)
    begin
        b_hold_reg    <= b_hold_next;
        n_reg         <= n_next;
        j_reg         <= j_next;
        raw_end_reg   <= raw_end_next;
        start_reg     <= start_next;
        hdr_idx_reg   <= hdr_idx_next;
        hdr_last_reg  <= hdr_last_next;
        ovf_hold_reg  <= ovf_hold_next;
        last_hold_reg <= last_hold_next;
        sub_reg       <= sub_next;
        if (mem_we && cnt < IDX_W'(3))
            first_reg[cnt[1:0]] <= stream.data_byte;
        if (emit_go)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_final;
            out_eot_reg  <= emit_final && !emit_kind && last_hold_reg;
            out_ovf_reg  <= !emit_kind && ovf_hold_reg;
        end
    end

    // Writes happen only on accept and reads only during a walk, so the two
    // never meet on the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cnt[ADDR_W-1:0]] <= stream.data_byte;
        if (state_reg == ST_FETCH && !j_is_last)
            rdata_reg <= mem[j_reg[ADDR_W-1:0]];
    end

    assign result.valid           = out_valid_reg;
    assign result.out_kind        = out_kind_reg;
    assign result.out_byte        = out_byte_reg;
    assign result.out_end_of_text = out_eot_reg;
    assign result.out_last        = out_last_reg;
    assign result.prefix_overflow = out_ovf_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IDX_W'(PREFIX_DEPTH))
        else $error("prefix count beyond store depth");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH || state_reg == ST_EMIT) |-> (j_reg < n_reg))
        else $error("walk index past the held text");

    a_event_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && stream.req_type != REQ_TEXT) |=> (state_reg == ST_EVT))
        else $error("accepted event did not move to its result");
`endif

endmodule

`default_nettype wire

// ===== test/file_path_to_url_rewriter_top_test.sv =====
// Self-checking testbench of the file path to file URL rewriter.
`timescale 1ns / 100ps

module file_path_to_url_rewriter_top_test;

    import fpur_pkg::*;

    localparam logic       KIND_TEXT    = 1'b0;
    localparam logic       KIND_EVENT   = 1'b1;
    localparam logic [1:0] REQ_OTHER    = 2'd2;
    localparam logic [1:0] REQ_SPARE    = 2'd3;
    localparam int         OPENING_N    = 24;
    localparam int         RANDOM_N     = 72;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 200;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       eot;
        logic       last;
        logic       ovf;
    } url_word_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  data;
        logic        last;
        logic [31:0] head;
        logic [7:0]  len;
        logic        typed;
        url_word_t   word;
    } stim_row_t;

    localparam url_word_t EVENT_WORD = '{KIND_EVENT, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam url_word_t NO_WORD    = '0;

    logic clk;
    logic rst_n;

    fpur_stream_if stream_ch ();
    fpur_result_if result_ch ();

    file_path_to_url_rewriter_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    always #2 clk = ~clk;

    // Opening table: a typed word where the outcome is plain, else the predictor decides.
    stim_row_t opening_rows [OPENING_N] = '{
        '{REQ_OTHER, 8'h00, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, EVENT_WORD},
        '{REQ_START, 8'h00, 1'b0, 32'h4649_4C46, FILE_TAG_LEN, 1'b1, EVENT_WORD},
        '{REQ_TEXT, 8'h00, 1'b0, 32'h0, 8'h00, 1'b1,
          '{KIND_TEXT, 8'h00, 1'b0, 1'b1, 1'b0}},
        '{REQ_TEXT, 8'hFF, 1'b1, 32'h0, 8'h00, 1'b1,
          '{KIND_TEXT, 8'hFF, 1'b1, 1'b1, 1'b0}},
        '{REQ_START, 8'h00, 1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b1, EVENT_WORD},
        '{REQ_START, 8'h00, 1'b0, FILE_TAG, 8'd5, 1'b1, EVENT_WORD},
        '{REQ_START, 8'h00, 1'b0, FILE_TAG, FILE_TAG_LEN, 1'b1, EVENT_WORD},
        '{REQ_SPARE, 8'h00, 1'b0, 32'h0, 8'h00, 1'b1, EVENT_WORD},
        '{REQ_TEXT, "h", 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_COLON, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_SLASH, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_SLASH, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, "x", 1'b1, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_BSLASH, 1'b1, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, "C", 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_COLON, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_BSLASH, 1'b1, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_BSLASH, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_OTHER, 8'h00, 1'b0, 32'h0, 8'h00, 1'b1, EVENT_WORD},
        '{REQ_TEXT, CH_BSLASH, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, "s", 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_AT, 1'b1, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_SLASH, 1'b0, 32'h0, 8'h00, 1'b0, NO_WORD},
        '{REQ_TEXT, CH_QUEST, 1'b1, 32'h0, 8'h00, 1'b0, NO_WORD}
    };

    stim_row_t stim_q [$];

    // Predictor state.
    logic        tag_is_file;
    logic [7:0]  held_bytes [PREFIX_DEPTH];
    int          held_cnt;
    logic [2:0]  scan_phase;
    logic [1:0]  text_state;
    logic [7:0]  walk_bytes [PREFIX_DEPTH + 1];
    url_word_t   step_words [$];
    url_word_t   pending_words [$];

    int  cycle_cnt      = 0;
    int  items_sent     = 0;
    int  words_checked  = 0;
    int  overflow_words = 0;
    int  fail_cnt       = 0;
    bit  steady_stretch = 1'b0;

    function automatic logic letter_byte(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    // Scheme scan: a letter and a run without slashes, colon, slashes, then the first byte that is not a slash.
    function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic [7:0] b);
        logic [2:0] np;
        case (ph)
            PH_SCHEME:
            begin
                if (b == CH_COLON)
                    np = PH_COLON;
                else if (b == CH_SLASH || b == CH_BSLASH)
                    np = PH_NONE;
                else
                    np = PH_SCHEME;
            end
            PH_COLON, PH_SLASH1:
                np = (b == CH_SLASH) ? ph + 3'd1 : PH_NONE;
            PH_SLASH2:
                np = (b == CH_SLASH) ? PH_SLASH2 : PH_URL;
            default:
                np = PH_NONE;
        endcase
        return np;
    endfunction

    task automatic put_word(input logic kind, input logic [7:0] ch, input logic ovf);
        url_word_t w;
        w = '{kind, ch, 1'b0, 1'b0, ovf};
        step_words.push_back(w);
    endtask

    task automatic put_escape(input logic [7:0] hi, input logic [7:0] lo, input logic ovf);
        put_word(KIND_TEXT, CH_PCT, ovf);
        put_word(KIND_TEXT, hi, ovf);
        put_word(KIND_TEXT, lo, ovf);
    endtask

    task automatic put_path_byte(input logic [7:0] b, input logic ovf);
        case (b)
            CH_BSLASH: put_word(KIND_TEXT, CH_SLASH, ovf);
            CH_COLON:  put_escape("3", "a", ovf);
            CH_QUEST:  put_escape("3", "F", ovf);
            CH_HASH:   put_escape("2", "3", ovf);
            CH_LBRACK: put_escape("5", "B", ovf);
            CH_RBRACK: put_escape("5", "D", ovf);
            CH_AT:     put_escape("4", "0", ovf);
            default:   put_word(KIND_TEXT, b, ovf);
        endcase
    endtask

    task automatic put_header(input logic triple, input logic ovf);
        string hdr;
        int    k;
        hdr = triple ? "file:///" : "file://";
        for (k = 0; k < hdr.len(); k++)
            put_word(KIND_TEXT, hdr[k], ovf);
    endtask

    task automatic release_path(input int n, input logic ovf);
        int i;
        i = 0;
        if (walk_bytes[0] == CH_SLASH)
            put_header(1'b0, ovf);
        else if (walk_bytes[0] == CH_BSLASH)
        begin
            put_header(1'b0, ovf);
            // A share name drops its two backslashes, unless a third one follows.
            if (n > 1 && walk_bytes[1] == CH_BSLASH && !(n > 2 && walk_bytes[2] == CH_BSLASH))
                i = 2;
        end
        else if (letter_byte(walk_bytes[0]) && n > 2 && walk_bytes[1] == CH_COLON &&
                 walk_bytes[2] == CH_BSLASH)
        begin
            put_header(1'b1, ovf);
            put_word(KIND_TEXT, walk_bytes[0], ovf);
            put_word(KIND_TEXT, walk_bytes[1], ovf);
            i = 2;
        end
        while (i < n)
        begin
            put_path_byte(walk_bytes[i], ovf);
            i++;
        end
    endtask

    task automatic rewrite_item(input stim_row_t r);
        int         n;
        int         k;
        logic [2:0] np;
        url_word_t  w;
        step_words.delete();
        if (r.req != REQ_TEXT)
        begin
            if (r.req == REQ_START)
                tag_is_file = (r.len == FILE_TAG_LEN && r.head == FILE_TAG);
            put_word(KIND_EVENT, 8'h00, 1'b0);
        end
        else
        begin
            if (text_state == MODE_START)
            begin
                if (tag_is_file)
                begin
                    text_state = MODE_HOLD;
                    held_cnt   = 0;
                    scan_phase = letter_byte(r.data) ? PH_SCHEME : PH_NONE;
                end
                else
                    text_state = MODE_PASS;
            end
            case (text_state)
                MODE_HOLD:
                begin
                    n = (held_cnt > PREFIX_DEPTH) ? PREFIX_DEPTH : held_cnt;
                    for (k = 0; k < n; k++)
                        walk_bytes[k] = held_bytes[k];
                    walk_bytes[n] = r.data;
                    n++;
                    np = next_phase(scan_phase, r.data);
                    if (np == PH_URL)
                    begin
                        for (k = 0; k < n; k++)
                            put_word(KIND_TEXT, walk_bytes[k], 1'b0);
                        text_state = MODE_PASS;
                    end
                    else if ((np == PH_NONE && n >= 3) || r.last)
                    begin
                        release_path(n, 1'b0);
                        text_state = MODE_PATH;
                        scan_phase = PH_NONE;
                    end
                    else if (held_cnt >= PREFIX_DEPTH)
                    begin
                        // Still undecided with a full store: treated as a path and flagged.
                        release_path(n, 1'b1);
                        text_state = MODE_PATH;
                        scan_phase = PH_SCHEME;
                    end
                    else
                    begin
                        held_bytes[held_cnt] = r.data;
                        held_cnt++;
                        scan_phase = np;
                    end
                end
                MODE_PASS:
                    put_word(KIND_TEXT, r.data, 1'b0);
                default:
                    put_path_byte(r.data, scan_phase[0]);
            endcase
            if (r.last)
            begin
                text_state = MODE_START;
                held_cnt   = 0;
                scan_phase = PH_NONE;
            end
        end
        if (step_words.size() > 0)
        begin
            w = step_words.pop_back();
            w.last = 1'b1;
            if (r.req == REQ_TEXT && r.last)
                w.eot = 1'b1;
            step_words.push_back(w);
        end
    endtask

    task automatic take_item(input stim_row_t r);
        rewrite_item(r);
        if (r.typed)
            pending_words.push_back(r.word);
        else
            foreach (step_words[k])
                pending_words.push_back(step_words[k]);
        items_sent++;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_path_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = CH_BSLASH;
            1:       b = CH_SLASH;
            2:       b = CH_COLON;
            3:       b = CH_QUEST;
            4:       b = CH_HASH;
            5:       b = CH_LBRACK;
            6:       b = CH_RBRACK;
            7:       b = CH_AT;
            8:       b = 8'($urandom);
            default: b = rand_letter();
        endcase
        return b;
    endfunction

    task automatic add_word(input logic [1:0] req, input logic [7:0] b, input logic fin,
                            input logic [31:0] head, input logic [7:0] len);
        stim_row_t r;
        r = '{req, b, fin, head, len, 1'b0, NO_WORD};
        stim_q.push_back(r);
    endtask

    task automatic add_event();
        add_word($urandom_range(0, 1) ? REQ_OTHER : REQ_SPARE, 8'($urandom), 1'($urandom),
                 $urandom, 8'($urandom));
    endtask

    task automatic add_tag();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                add_word(REQ_START, 8'($urandom), 1'b0, FILE_TAG, FILE_TAG_LEN);
            6:
                add_word(REQ_START, 8'($urandom), 1'b0, $urandom, 8'($urandom));
            7:
            begin
                if ($urandom_range(0, 1))
                    add_word(REQ_START, 8'h00, 1'b0,
                             FILE_TAG ^ (32'd1 << $urandom_range(0, 31)), FILE_TAG_LEN);
                else
                    add_word(REQ_START, 8'h00, 1'b0, FILE_TAG, 8'($urandom_range(0, 8)));
            end
            8:
                add_event();
            default:
                ;
        endcase
    endtask

    // One text of a given shape, now and then split by an event.
    task automatic add_text(input int shape);
        logic [7:0] txt [$];
        logic [7:0] b;
        int         k;
        case (shape)
            0:
            begin
                txt.push_back(rand_letter());
                repeat ($urandom_range(0, 3)) txt.push_back(rand_letter());
                txt.push_back(CH_COLON);
                repeat ($urandom_range(2, 3)) txt.push_back(CH_SLASH);
                b = 8'($urandom);
                txt.push_back(b == CH_SLASH ? "x" : b);
            end
            1:
            begin
                txt.push_back(rand_letter());
                txt.push_back(CH_COLON);
                txt.push_back(CH_BSLASH);
            end
            2:
                repeat (2) txt.push_back(CH_BSLASH);
            3:
                repeat (3) txt.push_back(CH_BSLASH);
            4:
                txt.push_back(CH_SLASH);
            5:
                repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom));
            6:
            begin
                txt.push_back(rand_letter());
                repeat ($urandom_range(15, 20)) txt.push_back(rand_letter());
            end
            default:
            begin
                txt.push_back(rand_letter());
                txt.push_back(CH_COLON);
                if ($urandom_range(0, 1))
                    txt.push_back(CH_SLASH);
            end
        endcase
        repeat ($urandom_range(0, 5)) txt.push_back(rand_path_byte());
        for (k = 0; k < txt.size(); k++)
        begin
            add_word(REQ_TEXT, txt[k], k == txt.size() - 1, $urandom, 8'($urandom));
            if (k < txt.size() - 1 && $urandom_range(0, 11) == 0)
                add_event();
        end
    endtask

    task automatic check_word(input url_word_t got);
        url_word_t want;
        if (pending_words.size() == 0)
        begin
            $error("unexpected result word: out_kind %0d, out_byte %02h", got.kind, got.ch);
            fail_cnt++;
        end
        else
        begin
            want = pending_words.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
                fail_cnt++;
            end
            if (got.ch !== want.ch)
            begin
                $error("out_byte: expected %02h, got %02h", want.ch, got.ch);
                fail_cnt++;
            end
            if (got.eot !== want.eot)
            begin
                $error("out_end_of_text: expected %0d, got %0d", want.eot, got.eot);
                fail_cnt++;
            end
            if (got.last !== want.last)
            begin
                $error("out_last: expected %0d, got %0d", want.last, got.last);
                fail_cnt++;
            end
            if (got.ovf !== want.ovf)
            begin
                $error("prefix_overflow: expected %0d, got %0d", want.ovf, got.ovf);
                fail_cnt++;
            end
        end
        if (got.ovf === 1'b1)
            overflow_words++;
        words_checked++;
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycle_cnt, pending_words.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the block backs up.
    initial
    begin
        int  hold_left;
        bit  held_off;
        hold_left       = 0;
        held_off        = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                check_word('{result_ch.out_kind, result_ch.out_byte, result_ch.out_end_of_text,
                             result_ch.out_last, result_ch.prefix_overflow});
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!held_off && words_checked >= 50)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady_stretch || $urandom_range(0, 99) >= 24;
        end
    end

    initial
    begin
        int cur;
        bit steady;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        stream_ch.valid      = 1'b0;
        stream_ch.req_type   = REQ_TEXT;
        stream_ch.data_byte  = 8'h00;
        stream_ch.text_last  = 1'b0;
        stream_ch.tag_head   = 32'h0;
        stream_ch.tag_length = 8'h00;

        tag_is_file = 1'b0;
        held_cnt    = 0;
        scan_phase  = PH_NONE;
        text_state  = MODE_START;

        foreach (opening_rows[k])
            stim_q.push_back(opening_rows[k]);
        // The first random text is a long undecided one inside a FILE tag.
        add_word(REQ_START, 8'h00, 1'b0, FILE_TAG, FILE_TAG_LEN);
        add_text(6);
        while (stim_q.size() < OPENING_N + RANDOM_N)
        begin
            add_tag();
            add_text($urandom_range(0, 7));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        cur = 0;
        while (cur < stim_q.size())
        begin
            @(posedge clk);
            if (stream_ch.valid && stream_ch.ready)
            begin
                take_item(stim_q[cur]);
                cur++;
            end
            steady = cur >= 40 && cur < 75;
            steady_stretch <= steady;
            if (!stream_ch.valid || stream_ch.ready)
            begin
                if (cur < stim_q.size() && (steady || $urandom_range(0, 99) >= 24))
                begin
                    stream_ch.valid      <= 1'b1;
                    stream_ch.req_type   <= stim_q[cur].req;
                    stream_ch.data_byte  <= stim_q[cur].data;
                    stream_ch.text_last  <= stim_q[cur].last;
                    stream_ch.tag_head   <= stim_q[cur].head;
                    stream_ch.tag_length <= stim_q[cur].len;
                end
                else
                    stream_ch.valid <= 1'b0;
            end
        end

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input words (%0d from the opening table) and checked %0d results.",
                 items_sent, OPENING_N, words_checked);
        $display("%0d results carried the overflow mark; the receiver held off once for %0d cycles.",
                 overflow_words, HOLD_CYCLES);
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
